// File: rtl/dpr_pkg.sv
package dpr_pkg;

    // Field widths fixed by the interface
    localparam int PW_W  = 12;
    localparam int CMD_W = 13;

    typedef logic [PW_W-1:0]         pw_t;
    typedef logic signed [CMD_W-1:0] cmd_t;

    // Width commanded by a zero command
    localparam pw_t STOP_WIDTH = 12'd1500;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_FWD_ONE_LOW  = 3'd0,
        REG_FWD_ONE_HIGH = 3'd1,
        REG_REV_ONE_LOW  = 3'd2,
        REG_REV_ONE_HIGH = 3'd3,
        REG_FWD_TWO_LOW  = 3'd4,
        REG_FWD_TWO_HIGH = 3'd5,
        REG_REV_TWO_LOW  = 3'd6,
        REG_REV_TWO_HIGH = 3'd7
    } reg_idx_t;

    // Calibration reset values
    localparam pw_t FWD_ONE_LOW_RST  = 12'd1606;
    localparam pw_t FWD_ONE_HIGH_RST = 12'd1942;
    localparam pw_t REV_ONE_LOW_RST  = 12'd1063;
    localparam pw_t REV_ONE_HIGH_RST = 12'd1399;
    localparam pw_t FWD_TWO_LOW_RST  = 12'd1615;
    localparam pw_t FWD_TWO_HIGH_RST = 12'd1951;
    localparam pw_t REV_TWO_LOW_RST  = 12'd1055;
    localparam pw_t REV_TWO_HIGH_RST = 12'd1391;

    // Calibration spans of one channel
    typedef struct packed {
        pw_t fwd_low;
        pw_t fwd_high;
        pw_t rev_low;
        pw_t rev_high;
    } span_t;

endpackage

// File: rtl/dpr_if.sv
interface dpr_tick_if;
    import dpr_pkg::*;

    logic valid;
    logic ready;
    cmd_t command_one;
    cmd_t command_two;
    logic update_one;
    logic update_two;

    modport source (output valid, output command_one, output command_two,
                    output update_one, output update_two, input ready);
    modport sink   (input valid, input command_one, input command_two,
                    input update_one, input update_two, output ready);
endinterface

interface dpr_result_if;
    import dpr_pkg::*;

    logic valid;
    logic ready;
    pw_t  pulse_one;
    pw_t  pulse_two;
    logic settled;

    modport source (output valid, output pulse_one, output pulse_two,
                    output settled, input ready);
    modport sink   (input valid, input pulse_one, input pulse_two,
                    input settled, output ready);
endinterface

// File: rtl/dual_esc_pulse_ramp_unit.sv
// Two-channel thruster pulse ramp. Each tick transaction maps the signed
// command of every enabled channel onto its forward or reverse calibration
// span and moves the stored pulse width toward that target by
// ceil(gap / RATE_DIVISOR); a disabled channel holds. The block takes one
// tick per cycle while the result side does not stall, and passes it through
// an input register, a span multiply stage, a reciprocal divide stage and the
// output register, whose load closes the per-channel ramp loop (subtract,
// reciprocal multiply, add) combinationally. Calibration registers must be
// written through the cfg port while no tick is in flight; the block itself
// does not enforce this. No clearing pass is needed after reset.
module dual_esc_pulse_ramp_unit #(
    parameter int COMMAND_MAX  = 3200,
    parameter int RATE_DIVISOR = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    dpr_tick_if.sink          tick,
    dpr_result_if.source      result,
    input  logic              cfg_we,
    input  dpr_pkg::reg_idx_t cfg_index,
    input  dpr_pkg::pw_t      cfg_data
);
    import dpr_pkg::*;

    span_t span_one;
    span_t span_two;
    pw_t   target_one;
    pw_t   target_two;
    logic  at_one;
    logic  at_two;

    // Stage valids and handshake
    logic v0_reg;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic rdy0;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic ld0;
    logic ld1;
    logic ld2;
    logic ld3;

    // Payload carried beside the datapath
    cmd_t cmd_one_reg;
    cmd_t cmd_two_reg;
    logic upd_one0_reg;
    logic upd_two0_reg;
    logic upd_one1_reg;
    logic upd_two1_reg;
    logic upd_one2_reg;
    logic upd_two2_reg;
    logic settled_reg;

    // Each stage takes a transaction when empty or when its own moves on
    assign rdy3 = !v3_reg || result.ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;
    assign ld0  = tick.valid && rdy0;
    assign ld1  = v0_reg && rdy1;
    assign ld2  = v1_reg && rdy2;
    assign ld3  = v2_reg && rdy3;

    assign tick.ready = rdy0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            settled_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= tick.valid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (ld3)
                settled_reg <= at_one && at_two;
        end
    end

    // Capture the tick and pass the update flags along
    always_ff @(posedge clk)
    begin
        if (ld0)
        begin
            cmd_one_reg  <= tick.command_one;
            cmd_two_reg  <= tick.command_two;
            upd_one0_reg <= tick.update_one;
            upd_two0_reg <= tick.update_two;
        end
        if (ld1)
        begin
            upd_one1_reg <= upd_one0_reg;
            upd_two1_reg <= upd_two0_reg;
        end
        if (ld2)
        begin
            upd_one2_reg <= upd_one1_reg;
            upd_two2_reg <= upd_two1_reg;
        end
    end

    dpr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .span_one  (span_one),
        .span_two  (span_two)
    );

    dpr_target #(.COMMAND_MAX(COMMAND_MAX)) u_target_one (
        .clk         (clk),
        .load_prod   (ld1),
        .load_target (ld2),
        .command     (cmd_one_reg),
        .span        (span_one),
        .target      (target_one)
    );

    dpr_target #(.COMMAND_MAX(COMMAND_MAX)) u_target_two (
        .clk         (clk),
        .load_prod   (ld1),
        .load_target (ld2),
        .command     (cmd_two_reg),
        .span        (span_two),
        .target      (target_two)
    );

    dpr_ramp #(.RATE_DIVISOR(RATE_DIVISOR)) u_ramp_one (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ld3),
        .update    (upd_one2_reg),
        .target    (target_one),
        .width     (result.pulse_one),
        .at_target (at_one)
    );

    dpr_ramp #(.RATE_DIVISOR(RATE_DIVISOR)) u_ramp_two (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ld3),
        .update    (upd_two2_reg),
        .target    (target_two),
        .width     (result.pulse_two),
        .at_target (at_two)
    );

    assign result.valid   = v3_reg;
    assign result.settled = settled_reg;

    // Widths move only when a result is loaded
    a_width_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ld3 |=> ($stable(result.pulse_one) && $stable(result.pulse_two)))
        else $error("pulse width changed without a result load");

    // A full pipeline with a stalled output refuses new ticks
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v0_reg && v1_reg && v2_reg && v3_reg && !result.ready) |-> !tick.ready)
        else $error("tick accepted into a full stalled pipeline");

    // A tick that updates neither channel leaves both settled
    a_hold_settled: assert property (@(posedge clk) disable iff (!rst_n)
        (ld3 && !upd_one2_reg && !upd_two2_reg) |=> result.settled)
        else $error("hold tick not reported as settled");

endmodule

// File: rtl/dpr_cfg_regs.sv
module dpr_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  dpr_pkg::reg_idx_t cfg_index,
    input  dpr_pkg::pw_t      cfg_data,
    output dpr_pkg::span_t    span_one,
    output dpr_pkg::span_t    span_two
);
    import dpr_pkg::*;

    span_t span_one_reg;
    span_t span_two_reg;

    // Write one calibration register per enabled cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_one_reg <= '{FWD_ONE_LOW_RST, FWD_ONE_HIGH_RST,
                              REV_ONE_LOW_RST, REV_ONE_HIGH_RST};
            span_two_reg <= '{FWD_TWO_LOW_RST, FWD_TWO_HIGH_RST,
                              REV_TWO_LOW_RST, REV_TWO_HIGH_RST};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FWD_ONE_LOW:  span_one_reg.fwd_low  <= cfg_data;
                REG_FWD_ONE_HIGH: span_one_reg.fwd_high <= cfg_data;
                REG_REV_ONE_LOW:  span_one_reg.rev_low  <= cfg_data;
                REG_REV_ONE_HIGH: span_one_reg.rev_high <= cfg_data;
                REG_FWD_TWO_LOW:  span_two_reg.fwd_low  <= cfg_data;
                REG_FWD_TWO_HIGH: span_two_reg.fwd_high <= cfg_data;
                REG_REV_TWO_LOW:  span_two_reg.rev_low  <= cfg_data;
                REG_REV_TWO_HIGH: span_two_reg.rev_high <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign span_one = span_one_reg;
    assign span_two = span_two_reg;

endmodule

// File: rtl/dpr_target.sv
module dpr_target #(
    parameter int COMMAND_MAX = 3200
) (
    input  logic           clk,
    input  logic           load_prod,
    input  logic           load_target,
    input  dpr_pkg::cmd_t  command,
    input  dpr_pkg::span_t span,
    output dpr_pkg::pw_t   target
);
    import dpr_pkg::*;

    // Map divisor and its exact reciprocal
    localparam int DIV   = COMMAND_MAX - 1;
    localparam int EXT_W = 17;
    localparam int OFF_W = (COMMAND_MAX > 2) ? $clog2(COMMAND_MAX) : 1;
    localparam int P_W   = OFF_W + PW_W;
    localparam int SH    = P_W + $clog2(DIV);
    localparam int M_W   = P_W + 1;
    localparam int Q_W   = P_W + M_W;
    localparam logic [63:0] M_FULL =
        ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic signed [EXT_W-1:0] CMAX = EXT_W'(COMMAND_MAX);

    logic signed [EXT_W-1:0] cmd_ext;
    logic signed [EXT_W-1:0] cmd_sat;
    logic signed [EXT_W-1:0] off_full;
    logic                    is_pos;
    logic                    is_zero;
    pw_t                     lo;
    pw_t                     hi;
    logic                    down;
    pw_t                     mag;
    logic [P_W-1:0]          prod;
    logic [Q_W-1:0]          quot_full;
    pw_t                     quot;

    logic [P_W-1:0] prod_reg;
    pw_t            lo_reg;
    logic           down_reg;
    logic           zero_reg;
    pw_t            target_reg;
    pw_t            target_next;

    // Saturate the command, pick the span and form offset times span
    always_comb
    begin
        cmd_ext = {{(EXT_W-CMD_W){command[CMD_W-1]}}, command};
        if (cmd_ext > CMAX)
            cmd_sat = CMAX;
        else if (cmd_ext < -CMAX)
            cmd_sat = -CMAX;
        else
            cmd_sat = cmd_ext;
        is_pos  = (cmd_sat > 0);
        is_zero = (cmd_sat == 0);
        lo       = is_pos ? span.fwd_low  : span.rev_low;
        hi       = is_pos ? span.fwd_high : span.rev_high;
        off_full = is_pos ? (cmd_sat - EXT_W'(1)) : (cmd_sat + CMAX);
        down     = (lo > hi);
        mag      = down ? (lo - hi) : (hi - lo);
        prod     = P_W'(off_full[OFF_W-1:0]) * P_W'(mag);
    end

    always_ff @(posedge clk)
    begin
        if (load_prod)
        begin
            prod_reg <= prod;
            lo_reg   <= lo;
            down_reg <= down;
            zero_reg <= is_zero;
        end
    end

    // Divide by reciprocal, truncate toward zero, offset from the span start
    always_comb
    begin
        quot_full = Q_W'(prod_reg) * Q_W'(M_FULL[M_W-1:0]);
        quot      = quot_full[SH +: PW_W];
        if (zero_reg)
            target_next = STOP_WIDTH;
        else if (down_reg)
            target_next = lo_reg - quot;
        else
            target_next = lo_reg + quot;
    end

    always_ff @(posedge clk)
    begin
        if (load_target)
            target_reg <= target_next;
    end

    assign target = target_reg;

endmodule

// File: rtl/dpr_ramp.sv
module dpr_ramp #(
    parameter int RATE_DIVISOR = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  logic         update,
    input  dpr_pkg::pw_t target,
    output dpr_pkg::pw_t width,
    output logic         at_target
);
    import dpr_pkg::*;

    // Ceiling divide of the gap as an exact reciprocal multiply
    localparam int NUM_W = $clog2(4095 + RATE_DIVISOR);
    localparam int SH    = NUM_W + $clog2(RATE_DIVISOR);
    localparam int M_W   = NUM_W + 1;
    localparam int Q_W   = NUM_W + M_W;
    localparam logic [63:0] M_FULL =
        ((64'd1 << SH) + 64'(RATE_DIVISOR) - 64'd1) / 64'(RATE_DIVISOR);

    pw_t              width_reg;
    pw_t              width_next;
    pw_t              goal;
    logic             up;
    pw_t              gap;
    logic [NUM_W-1:0] num;
    logic [Q_W-1:0]   step_full;
    pw_t              step;

    // Step toward the goal, never past it
    always_comb
    begin
        goal      = update ? target : width_reg;
        up        = (goal > width_reg);
        gap       = up ? (goal - width_reg) : (width_reg - goal);
        num       = NUM_W'(gap) + NUM_W'(RATE_DIVISOR - 1);
        step_full = Q_W'(num) * Q_W'(M_FULL[M_W-1:0]);
        step      = PW_W'(step_full[Q_W-1:SH]);
        width_next = up ? (width_reg + step) : (width_reg - step);
        at_target  = (width_next == goal);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            width_reg <= STOP_WIDTH;
        else if (load)
            width_reg <= width_next;
    end

    assign width = width_reg;

endmodule

// File: tb/sv/dual_esc_pulse_ramp_unit_tb.sv
`timescale 1ns / 1ps

module dual_esc_pulse_ramp_unit_tb;
    import dpr_pkg::*;

    localparam int CMD_LIMIT  = 3200;
    localparam int SLEW_DIV   = 20;
    localparam int PIPE_DEPTH = 4;
    localparam int LONG_HOLD  = 80;
    localparam int IDLE_LIMIT = 1000;

    // One expected output transaction
    typedef struct {
        pw_t  pulse_one;
        pw_t  pulse_two;
        logic settled;
    } pulse_result_t;

    // Tracks calibration and both pulse widths, queues the widths each tick should produce
    class pulse_scoreboard;
        pw_t           cal [8];
        pw_t           cur_one;
        pw_t           cur_two;
        pulse_result_t pulse_q [$];
        int            errors;
        int            ticks;
        int            results;
        int            settled_seen;
        int            cal_writes;

        function new();
            cal[REG_FWD_ONE_LOW]  = FWD_ONE_LOW_RST;
            cal[REG_FWD_ONE_HIGH] = FWD_ONE_HIGH_RST;
            cal[REG_REV_ONE_LOW]  = REV_ONE_LOW_RST;
            cal[REG_REV_ONE_HIGH] = REV_ONE_HIGH_RST;
            cal[REG_FWD_TWO_LOW]  = FWD_TWO_LOW_RST;
            cal[REG_FWD_TWO_HIGH] = FWD_TWO_HIGH_RST;
            cal[REG_REV_TWO_LOW]  = REV_TWO_LOW_RST;
            cal[REG_REV_TWO_HIGH] = REV_TWO_HIGH_RST;
            cur_one = STOP_WIDTH;
            cur_two = STOP_WIDTH;
        endfunction

        function void set_reg(reg_idx_t idx, pw_t val);
            cal[idx] = val;
            cal_writes++;
        endfunction

        function int pending();
            return pulse_q.size();
        endfunction

        // Map a command onto the forward or reverse span; saturate out-of-range commands
        function pw_t aim_width(cmd_t cmd, span_t sp);
            longint c;
            longint lo;
            longint hi;
            longint base;
            c = cmd;
            if (c > CMD_LIMIT)
                c = CMD_LIMIT;
            else if (c < -CMD_LIMIT)
                c = -CMD_LIMIT;
            if (c > 0)
            begin
                lo = sp.fwd_low;
                hi = sp.fwd_high;
                base = 1;
            end
            else if (c < 0)
            begin
                lo = sp.rev_low;
                hi = sp.rev_high;
                base = -CMD_LIMIT;
            end
            else
                return STOP_WIDTH;
            // Signed divide truncates toward zero, also for downward spans
            return pw_t'(lo + ((c - base) * (hi - lo)) / (CMD_LIMIT - 1));
        endfunction

        // Advance one width toward its target by ceil(gap / SLEW_DIV)
        function pw_t slew_step(pw_t w, pw_t t);
            int wi;
            int ti;
            wi = w;
            ti = t;
            if (ti > wi)
                return pw_t'(wi + (ti - wi + SLEW_DIV - 1) / SLEW_DIV);
            if (wi > ti)
                return pw_t'(wi - (wi - ti + SLEW_DIV - 1) / SLEW_DIV);
            return w;
        endfunction

        function void note_tick(cmd_t c1, cmd_t c2, logic u1, logic u2);
            pw_t           t1;
            pw_t           t2;
            pulse_result_t r;
            t1 = cur_one;
            t2 = cur_two;
            if (u1)
                t1 = aim_width(c1, span_t'({cal[REG_FWD_ONE_LOW], cal[REG_FWD_ONE_HIGH],
                                            cal[REG_REV_ONE_LOW], cal[REG_REV_ONE_HIGH]}));
            if (u2)
                t2 = aim_width(c2, span_t'({cal[REG_FWD_TWO_LOW], cal[REG_FWD_TWO_HIGH],
                                            cal[REG_REV_TWO_LOW], cal[REG_REV_TWO_HIGH]}));
            cur_one = slew_step(cur_one, t1);
            cur_two = slew_step(cur_two, t2);
            r.pulse_one = cur_one;
            r.pulse_two = cur_two;
            r.settled   = (cur_one == t1) && (cur_two == t2);
            pulse_q.push_back(r);
            ticks++;
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(pw_t p1, pw_t p2, logic s);
            pulse_result_t want;
            results++;
            if (s === 1'b1)
                settled_seen++;
            if (pulse_q.size() == 0)
            begin
                report($sformatf("unexpected result pulse_one=%0d pulse_two=%0d settled=%b",
                                 p1, p2, s));
                return;
            end
            want = pulse_q.pop_front();
            if (p1 !== want.pulse_one)
                report($sformatf("result %0d pulse_one got %0d want %0d",
                                 results, p1, want.pulse_one));
            if (p2 !== want.pulse_two)
                report($sformatf("result %0d pulse_two got %0d want %0d",
                                 results, p2, want.pulse_two));
            if (s !== want.settled)
                report($sformatf("result %0d settled got %b want %b",
                                 results, s, want.settled));
        endtask

        task flush();
            while (pulse_q.size() != 0)
            begin
                void'(pulse_q.pop_front());
                report("expected result never arrived");
            end
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_we;
    reg_idx_t cfg_index;
    pw_t      cfg_data;

    bit calm     = 1'b0;
    bit hold_req = 1'b0;
    int quiet_cycles = 0;

    pulse_scoreboard sb = new();

    dpr_tick_if   tick_ch();
    dpr_result_if result_ch();

    dual_esc_pulse_ramp_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mostly no gap, some short, a few long; none while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_command();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return 0;
        if (r == 2)
            return $urandom_range(0, 1) ? CMD_LIMIT : -CMD_LIMIT;
        if (r == 3)
            return $urandom_range(0, 1) ? 1 : -1;
        if (r < 6)
            return int'(cmd_t'($urandom));
        return int'($urandom_range(0, 2 * CMD_LIMIT)) - CMD_LIMIT;
    endfunction

    // Offer one tick transaction and hold it until accepted
    task automatic send_tick(input int c1, input int c2, input bit u1, input bit u2);
        int gap;
        tick_ch.valid       <= 1'b1;
        tick_ch.command_one <= cmd_t'(c1);
        tick_ch.command_two <= cmd_t'(c2);
        tick_ch.update_one  <= u1;
        tick_ch.update_two  <= u2;
        do
            @(posedge clk);
        while (tick_ch.ready !== 1'b1);
        gap = pick_gap();
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Mostly held commands long enough to settle, the rest raw noise
    task automatic random_ticks(input int n);
        int left;
        int run;
        int c1;
        int c2;
        left = n;
        while (left > 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                c1 = pick_command();
                c2 = pick_command();
                run = $urandom_range(1, 150);
                if (run > left)
                    run = left;
                repeat (run)
                    send_tick(c1, c2, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
                left -= run;
            end
            else
            begin
                send_tick(int'(cmd_t'($urandom)), int'(cmd_t'($urandom)),
                          $urandom_range(0, 1), $urandom_range(0, 1));
                left--;
            end
        end
    endtask

    // Stop offering, let the last accepted tick be noted, then wait for every result
    task automatic drain();
        tick_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Write all eight calibration registers back to back
    task automatic write_cal(input pw_t vals [8]);
        reg_idx_t r;
        r = r.first();
        repeat (r.num())
        begin
            cfg_we    <= 1'b1;
            cfg_index <= r;
            cfg_data  <= vals[r];
            @(posedge clk);
            r = r.next();
        end
        cfg_we <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold on request
    initial
    begin : rx_side
        int gap;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                gap = pick_gap();
                if (gap == 0)
                    result_ch.ready <= 1'b1;
                else
                begin
                    result_ch.ready <= 1'b0;
                    repeat (gap - 1) @(posedge clk);
                end
            end
        end
    end

    // Observe every transaction and register write; watch for a hang
    always @(posedge clk)
    begin : observe
        logic moved;
        moved = 1'b0;
        if (cfg_we === 1'b1)
        begin
            sb.set_reg(cfg_index, cfg_data);
            moved = 1'b1;
        end
        if (tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1)
        begin
            sb.note_tick(tick_ch.command_one, tick_ch.command_two,
                         tick_ch.update_one, tick_ch.update_two);
            moved = 1'b1;
        end
        if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            sb.check_result(result_ch.pulse_one, result_ch.pulse_two, result_ch.settled);
            moved = 1'b1;
        end
        if (moved)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        pw_t vals [8];
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_FWD_ONE_LOW;
        cfg_data            = '0;
        tick_ch.valid       = 1'b0;
        tick_ch.command_one = '0;
        tick_ch.command_two = '0;
        tick_ch.update_one  = 1'b0;
        tick_ch.update_two  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: stop, span ends, saturation, all-ones and sign-bit patterns, holds
        send_tick(0, 0, 1, 1);
        send_tick(CMD_LIMIT, -CMD_LIMIT, 1, 1);
        send_tick(1, -1, 1, 1);
        send_tick(-CMD_LIMIT, CMD_LIMIT, 1, 1);
        send_tick(-1, 1, 1, 1);
        send_tick(4095, -4096, 1, 1);
        send_tick(CMD_LIMIT + 1, -CMD_LIMIT - 1, 1, 1);
        send_tick(-4096, 4095, 1, 1);
        send_tick(0, 0, 0, 0);
        send_tick(CMD_LIMIT, -CMD_LIMIT, 0, 0);
        send_tick(CMD_LIMIT, CMD_LIMIT, 1, 0);
        send_tick(-CMD_LIMIT, -CMD_LIMIT, 0, 1);
        send_tick(1600, -1600, 1, 1);
        repeat (10) send_tick(0, 0, 1, 1);

        // Back-pressure: receiver holds off while ticks keep coming
        calm = 1'b1;
        hold_req = 1'b1;
        repeat (40) send_tick(pick_command(), pick_command(), 1, 1);
        calm = 1'b0;
        random_ticks(240);
        drain();

        // Random calibration, first stretch without idling
        foreach (vals[i])
            vals[i] = pw_t'($urandom);
        write_cal(vals);
        calm = 1'b1;
        random_ticks(120);
        calm = 1'b0;
        random_ticks(130);
        drain();

        // All spans at zero
        foreach (vals[i])
            vals[i] = '0;
        write_cal(vals);
        random_ticks(200);
        drain();

        // All spans at full scale
        foreach (vals[i])
            vals[i] = '1;
        write_cal(vals);
        random_ticks(200);
        drain();

        // Downward spans on both channels
        vals[REG_FWD_ONE_LOW]  = 12'd4095;
        vals[REG_FWD_ONE_HIGH] = 12'd0;
        vals[REG_REV_ONE_LOW]  = 12'd3000;
        vals[REG_REV_ONE_HIGH] = 12'd17;
        vals[REG_FWD_TWO_LOW]  = 12'd2000;
        vals[REG_FWD_TWO_HIGH] = 12'd1999;
        vals[REG_REV_TWO_LOW]  = 12'd4000;
        vals[REG_REV_TWO_HIGH] = 12'd5;
        write_cal(vals);
        random_ticks(230);
        drain();

        repeat (PIPE_DEPTH + 4) @(posedge clk);
        sb.flush();
        $display("Coverage: %0d tick transactions, %0d results (%0d settled), %0d register writes",
                 sb.ticks, sb.results, sb.settled_seen, sb.cal_writes);
        $display("Spans: reset, random, all zero, full scale and downward, with long back-pressure");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
